// File: design/dasu_pkg.sv
`timescale 1ns / 1ps

package dasu_pkg;

   localparam int NUM_RESOURCES  = 4;
   localparam int CMD_BITS       = 2;
   localparam int PID_BITS       = 3;
   localparam int RID_BITS       = 2;
   localparam int VALUE_BITS     = 8;
   localparam int STATUS_BITS    = 3;
   localparam int SEQ_BITS       = 3;
   // The working vector is capped at this many bits and wraps at its width.
   localparam int WORK_WRAP_BITS = 19;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD_ENTRY = 2'd0,
      CMD_LOAD_AVAIL = 2'd1,
      CMD_REQUEST    = 2'd2,
      CMD_CHECK      = 2'd3
   } command_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_LOADED       = 3'd0,
      ST_EXCEEDS_NEED = 3'd1,
      ST_EXCEEDS_AVAIL = 3'd2,
      ST_UNSAFE       = 3'd3,
      ST_SAFE         = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       load_entry;
      logic       load_avail;
      logic       grant;
      logic       rollback;
      logic       test_init;
      logic       test_step;
      logic       scan_sel;
      logic       emit_load;
      logic       single_load;
      status_type status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      command_type command;
      logic        pid_valid;
      logic        exceeds_need;
      logic        exceeds_avail;
      logic        row_fits;
      logic        scan_last;
      logic        seq_full;
      logic        emit_last;
   } dp_status_type;

endpackage

// File: design/dasu_req_if.sv
`timescale 1ns / 1ps

interface dasu_req_if;
   logic                             valid;
   logic                             ready;
   logic [dasu_pkg::CMD_BITS-1:0]    command;
   logic [dasu_pkg::PID_BITS-1:0]    process_id;
   logic [dasu_pkg::RID_BITS-1:0]    resource_id;
   logic [dasu_pkg::VALUE_BITS-1:0]  allocation_value;
   logic [dasu_pkg::VALUE_BITS-1:0]  need_value;
   logic [dasu_pkg::VALUE_BITS-1:0]  available_value;
   logic [dasu_pkg::VALUE_BITS-1:0]  request_0;
   logic [dasu_pkg::VALUE_BITS-1:0]  request_1;
   logic [dasu_pkg::VALUE_BITS-1:0]  request_2;
   logic [dasu_pkg::VALUE_BITS-1:0]  request_3;

   modport source (
      output valid, command, process_id, resource_id, allocation_value, need_value,
             available_value, request_0, request_1, request_2, request_3,
      input  ready
   );

   modport sink (
      input  valid, command, process_id, resource_id, allocation_value, need_value,
             available_value, request_0, request_1, request_2, request_3,
      output ready
   );
endinterface

// File: design/dasu_rsp_if.sv
`timescale 1ns / 1ps

interface dasu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dasu_pkg::STATUS_BITS-1:0]  status;
   logic [dasu_pkg::SEQ_BITS-1:0]     seq_index;
   logic [dasu_pkg::SEQ_BITS-1:0]     seq_process;
   logic                              last;

   modport source (
      output valid, status, seq_index, seq_process, last,
      input  ready
   );

   modport sink (
      input  valid, status, seq_index, seq_process, last,
      output ready
   );
endinterface

// File: design/dasu_datapath.sv
`timescale 1ns / 1ps

module dasu_datapath #(
   parameter int NUM_PROCESSES = 5,
   parameter int COUNT_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dasu_pkg::dp_cmd_type              cmd,
   output dasu_pkg::dp_status_type           st,
   input  logic [dasu_pkg::CMD_BITS-1:0]     in_command,
   input  logic [dasu_pkg::PID_BITS-1:0]     in_process_id,
   input  logic [dasu_pkg::RID_BITS-1:0]     in_resource_id,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_allocation_value,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_need_value,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_available_value,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_request_0,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_request_1,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_request_2,
   input  logic [dasu_pkg::VALUE_BITS-1:0]   in_request_3,
   output logic [dasu_pkg::STATUS_BITS-1:0]  out_status,
   output logic [dasu_pkg::SEQ_BITS-1:0]     out_seq_index,
   output logic [dasu_pkg::SEQ_BITS-1:0]     out_seq_process,
   output logic                              out_last
);

   localparam int NR       = dasu_pkg::NUM_RESOURCES;
   localparam int VB       = dasu_pkg::VALUE_BITS;
   localparam int ROW_BITS = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int POS_BITS = $clog2(NUM_PROCESSES + 1);
   localparam int MB       = (COUNT_BITS > VB) ? COUNT_BITS : VB;
   localparam int WB       = (COUNT_BITS + 4 > dasu_pkg::WORK_WRAP_BITS) ?
                             dasu_pkg::WORK_WRAP_BITS : COUNT_BITS + 4;
   localparam logic [MB:0] COUNT_MAX = (MB + 1)'((1 << COUNT_BITS) - 1);

   // Captured input item.
   logic [dasu_pkg::CMD_BITS-1:0] cmd_ff, cmd_in;
   logic [dasu_pkg::PID_BITS-1:0] pid_ff, pid_in;
   logic [dasu_pkg::RID_BITS-1:0] rid_ff, rid_in;
   logic [VB-1:0]                 alloc_val_ff, alloc_val_in;
   logic [VB-1:0]                 need_val_ff, need_val_in;
   logic [VB-1:0]                 avail_val_ff, avail_val_in;
   logic [VB-1:0]                 req_ff [NR];
   logic [VB-1:0]                 req_in [NR];

   // Tables and rollback copies.
   logic [COUNT_BITS-1:0] avail_ff [NR];
   logic [COUNT_BITS-1:0] avail_in [NR];
   logic [COUNT_BITS-1:0] alloc_ff [NUM_PROCESSES][NR];
   logic [COUNT_BITS-1:0] alloc_in [NUM_PROCESSES][NR];
   logic [COUNT_BITS-1:0] need_ff  [NUM_PROCESSES][NR];
   logic [COUNT_BITS-1:0] need_in  [NUM_PROCESSES][NR];
   logic [COUNT_BITS-1:0] bak_avail_ff [NR];
   logic [COUNT_BITS-1:0] bak_avail_in [NR];
   logic [COUNT_BITS-1:0] bak_alloc_ff [NR];
   logic [COUNT_BITS-1:0] bak_alloc_in [NR];
   logic [COUNT_BITS-1:0] bak_need_ff  [NR];
   logic [COUNT_BITS-1:0] bak_need_in  [NR];

   // Safety test state.
   logic [WB-1:0]            work_ff [NR];
   logic [WB-1:0]            work_in [NR];
   logic [NUM_PROCESSES-1:0] fin_ff, fin_in;
   logic [ROW_BITS-1:0]      seq_ff [NUM_PROCESSES];
   logic [ROW_BITS-1:0]      seq_in [NUM_PROCESSES];
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [ROW_BITS-1:0]      scan_ff, scan_in;
   logic [ROW_BITS-1:0]      emit_ff, emit_in;

   // Output beat register.
   logic [dasu_pkg::STATUS_BITS-1:0] ostat_ff, ostat_in;
   logic [dasu_pkg::SEQ_BITS-1:0]    oidx_ff, oidx_in;
   logic [dasu_pkg::SEQ_BITS-1:0]    oproc_ff, oproc_in;
   logic                             olast_ff, olast_in;

   logic [ROW_BITS-1:0]   row_idx;
   logic [ROW_BITS-1:0]   wr_idx;
   logic [COUNT_BITS-1:0] sel_alloc [NR];
   logic [COUNT_BITS-1:0] sel_need  [NR];
   logic [COUNT_BITS-1:0] g_avail   [NR];
   logic [COUNT_BITS-1:0] g_alloc   [NR];
   logic [COUNT_BITS-1:0] g_need    [NR];
   logic                  over_need;
   logic                  over_avail;
   logic                  need_fits;
   logic                  fit;

   // One read port on the process rows: the scan index during the test, the
   // addressed process otherwise.
   assign row_idx = cmd.scan_sel ? scan_ff : pid_ff[ROW_BITS-1:0];
   assign wr_idx  = pid_ff[ROW_BITS-1:0];

   always_comb begin
      logic [MB:0] sum;
      over_need  = 1'b0;
      over_avail = 1'b0;
      need_fits  = 1'b1;
      for (int r = 0; r < NR; r++) begin
         sel_alloc[r] = alloc_ff[row_idx][r];
         sel_need[r]  = need_ff[row_idx][r];
         if (MB'(req_ff[r]) > MB'(sel_need[r])) begin
            over_need = 1'b1;
         end
         if (MB'(req_ff[r]) > MB'(avail_ff[r])) begin
            over_avail = 1'b1;
         end
         if (WB'(sel_need[r]) > work_ff[r]) begin
            need_fits = 1'b0;
         end
         g_avail[r] = COUNT_BITS'(MB'(avail_ff[r]) - MB'(req_ff[r]));
         g_need[r]  = COUNT_BITS'(MB'(sel_need[r]) - MB'(req_ff[r]));
         sum        = (MB + 1)'(sel_alloc[r]) + (MB + 1)'(req_ff[r]);
         g_alloc[r] = (sum > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(sum);
      end
      fit = !fin_ff[row_idx] && need_fits;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      rid_in       = rid_ff;
      alloc_val_in = alloc_val_ff;
      need_val_in  = need_val_ff;
      avail_val_in = avail_val_ff;
      req_in       = req_ff;
      avail_in     = avail_ff;
      alloc_in     = alloc_ff;
      need_in      = need_ff;
      bak_avail_in = bak_avail_ff;
      bak_alloc_in = bak_alloc_ff;
      bak_need_in  = bak_need_ff;
      work_in      = work_ff;
      fin_in       = fin_ff;
      seq_in       = seq_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      emit_in      = emit_ff;
      ostat_in     = ostat_ff;
      oidx_in      = oidx_ff;
      oproc_in     = oproc_ff;
      olast_in     = olast_ff;

      if (cmd.capture) begin
         cmd_in       = in_command;
         pid_in       = in_process_id;
         rid_in       = in_resource_id;
         alloc_val_in = in_allocation_value;
         need_val_in  = in_need_value;
         avail_val_in = in_available_value;
         req_in[0]    = in_request_0;
         req_in[1]    = in_request_1;
         req_in[2]    = in_request_2;
         req_in[3]    = in_request_3;
      end

      if (cmd.load_entry) begin
         alloc_in[wr_idx][rid_ff] = COUNT_BITS'(MB'(alloc_val_ff));
         need_in[wr_idx][rid_ff]  = COUNT_BITS'(MB'(need_val_ff));
      end

      if (cmd.load_avail) begin
         avail_in[rid_ff] = COUNT_BITS'(MB'(avail_val_ff));
      end

      if (cmd.grant) begin
         for (int r = 0; r < NR; r++) begin
            bak_avail_in[r]     = avail_ff[r];
            bak_alloc_in[r]     = sel_alloc[r];
            bak_need_in[r]      = sel_need[r];
            avail_in[r]         = g_avail[r];
            alloc_in[wr_idx][r] = g_alloc[r];
            need_in[wr_idx][r]  = g_need[r];
         end
      end

      if (cmd.rollback) begin
         for (int r = 0; r < NR; r++) begin
            avail_in[r]         = bak_avail_ff[r];
            alloc_in[wr_idx][r] = bak_alloc_ff[r];
            need_in[wr_idx][r]  = bak_need_ff[r];
         end
      end

      if (cmd.test_init) begin
         for (int r = 0; r < NR; r++) begin
            work_in[r] = WB'(avail_ff[r]);
         end
         fin_in  = '0;
         pos_in  = '0;
         scan_in = '0;
         emit_in = '0;
      end

      if (cmd.test_step) begin
         if (fit) begin
            // Take this process and restart the scan from the first row.
            for (int r = 0; r < NR; r++) begin
               work_in[r] = work_ff[r] + WB'(sel_alloc[r]);
            end
            fin_in[row_idx]                = 1'b1;
            seq_in[pos_ff[ROW_BITS-1:0]]   = row_idx;
            pos_in                         = pos_ff + POS_BITS'(1);
            scan_in                        = '0;
         end else begin
            scan_in = scan_ff + ROW_BITS'(1);
         end
      end

      if (cmd.single_load) begin
         ostat_in = cmd.status;
         oidx_in  = '0;
         oproc_in = '0;
         olast_in = 1'b1;
      end

      if (cmd.emit_load) begin
         ostat_in = dasu_pkg::ST_SAFE;
         oidx_in  = dasu_pkg::SEQ_BITS'(emit_ff);
         oproc_in = dasu_pkg::SEQ_BITS'(seq_ff[emit_ff]);
         olast_in = (emit_ff == ROW_BITS'(NUM_PROCESSES - 1));
         emit_in  = emit_ff + ROW_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NR; r++) begin
            avail_ff[r] <= '0;
            work_ff[r]  <= '0;
            for (int p = 0; p < NUM_PROCESSES; p++) begin
               alloc_ff[p][r] <= '0;
               need_ff[p][r]  <= '0;
            end
         end
         fin_ff  <= '0;
         pos_ff  <= '0;
         scan_ff <= '0;
         emit_ff <= '0;
      end else begin
         avail_ff <= avail_in;
         alloc_ff <= alloc_in;
         need_ff  <= need_in;
         work_ff  <= work_in;
         fin_ff   <= fin_in;
         pos_ff   <= pos_in;
         scan_ff  <= scan_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pid_ff       <= pid_in;
      rid_ff       <= rid_in;
      alloc_val_ff <= alloc_val_in;
      need_val_ff  <= need_val_in;
      avail_val_ff <= avail_val_in;
      req_ff       <= req_in;
      bak_avail_ff <= bak_avail_in;
      bak_alloc_ff <= bak_alloc_in;
      bak_need_ff  <= bak_need_in;
      seq_ff       <= seq_in;
      ostat_ff     <= ostat_in;
      oidx_ff      <= oidx_in;
      oproc_ff     <= oproc_in;
      olast_ff     <= olast_in;
   end

   assign st.command       = dasu_pkg::command_type'(cmd_ff);
   assign st.pid_valid     = ({1'b0, pid_ff} < (dasu_pkg::PID_BITS + 1)'(NUM_PROCESSES));
   assign st.exceeds_need  = over_need;
   assign st.exceeds_avail = over_avail;
   assign st.row_fits      = fit;
   assign st.scan_last     = (scan_ff == ROW_BITS'(NUM_PROCESSES - 1));
   assign st.seq_full      = (pos_ff == POS_BITS'(NUM_PROCESSES - 1));
   assign st.emit_last     = (emit_ff == ROW_BITS'(NUM_PROCESSES - 1));

   assign out_status      = ostat_ff;
   assign out_seq_index   = oidx_ff;
   assign out_seq_process = oproc_ff;
   assign out_last        = olast_ff;

endmodule

// File: design/dasu_ctrl.sv
`timescale 1ns / 1ps

module dasu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dasu_pkg::dp_cmd_type    cmd,
   input  dasu_pkg::dp_status_type st
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_INIT   = 6'b000100,
      S_SCAN   = 6'b001000,
      S_EMIT   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   dasu_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 out_load;

   // The output register can take a new beat when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.status = status_ff;
      out_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end

         S_DECODE: begin
            unique case (st.command)
               dasu_pkg::CMD_LOAD_ENTRY: begin
                  cmd.load_entry = st.pid_valid;
                  status_in      = dasu_pkg::ST_LOADED;
                  state_in       = S_RESP;
               end
               dasu_pkg::CMD_LOAD_AVAIL: begin
                  cmd.load_avail = 1'b1;
                  status_in      = dasu_pkg::ST_LOADED;
                  state_in       = S_RESP;
               end
               dasu_pkg::CMD_CHECK: begin
                  state_in = S_INIT;
               end
               dasu_pkg::CMD_REQUEST: begin
                  if (!st.pid_valid || st.exceeds_need) begin
                     status_in = dasu_pkg::ST_EXCEEDS_NEED;
                     state_in  = S_RESP;
                  end else if (st.exceeds_avail) begin
                     status_in = dasu_pkg::ST_EXCEEDS_AVAIL;
                     state_in  = S_RESP;
                  end else begin
                     cmd.grant = 1'b1;
                     state_in  = S_INIT;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_INIT: begin
            cmd.test_init = 1'b1;
            state_in      = S_SCAN;
         end

         S_SCAN: begin
            cmd.scan_sel  = 1'b1;
            cmd.test_step = 1'b1;
            if (st.row_fits) begin
               if (st.seq_full) begin
                  state_in = S_EMIT;
               end
            end else if (st.scan_last) begin
               // No unfinished process fits: the state is unsafe.
               cmd.rollback = (st.command == dasu_pkg::CMD_REQUEST);
               status_in    = dasu_pkg::ST_UNSAFE;
               state_in     = S_RESP;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               cmd.emit_load = 1'b1;
               out_load      = 1'b1;
               if (st.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               cmd.single_load = 1'b1;
               out_load        = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= dasu_pkg::ST_LOADED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/deadlock_avoidance_safety_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// req      in   command, process_id, resource_id, allocation/need/available value,
//                request_0..request_3
// rsp      out  status, seq_index, seq_process, last
//
// A load or a refused request goes through the idle, decode and response states, the last of
// which loads its result beat. A check or a granted request goes through the idle, decode
// and init states, then the safety scan at one process row per cycle, then its result beats.
// The single row read port of the process tables sets the length of the scan.
// Reset is synchronous and clears the tables and available vector to zero.
// A stalled beat holds the output register and delays the next beat while it stalls; the
// next item is accepted while the final beat of the previous one still waits.

module deadlock_avoidance_safety_unit #(
   parameter int NUM_PROCESSES = 5,
   parameter int COUNT_BITS    = 8
) (
   input logic        clock,
   input logic        reset,
   dasu_req_if.sink   req,
   dasu_rsp_if.source rsp
);

   dasu_pkg::dp_cmd_type    cmd;
   dasu_pkg::dp_status_type st;

   dasu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .st        (st)
   );

   dasu_datapath #(
      .NUM_PROCESSES (NUM_PROCESSES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .in_command          (req.command),
      .in_process_id       (req.process_id),
      .in_resource_id      (req.resource_id),
      .in_allocation_value (req.allocation_value),
      .in_need_value       (req.need_value),
      .in_available_value  (req.available_value),
      .in_request_0        (req.request_0),
      .in_request_1        (req.request_1),
      .in_request_2        (req.request_2),
      .in_request_3        (req.request_3),
      .out_status          (rsp.status),
      .out_seq_index       (rsp.seq_index),
      .out_seq_process     (rsp.seq_process),
      .out_last            (rsp.last)
   );

endmodule

// File: design/dasu_checker.sv
`timescale 1ns / 1ps

module dasu_checker #(
   parameter int NUM_PROCESSES = 5
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [dasu_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [dasu_pkg::SEQ_BITS-1:0]    rsp_seq_index,
   input logic [dasu_pkg::SEQ_BITS-1:0]    rsp_seq_process,
   input logic                             rsp_last
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_seq_index, rsp_seq_process, rsp_last}))
      else $error("result beat changed while stalled");

   // Every outcome other than safe is a single beat with zero sequence fields.
   a_single_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dasu_pkg::ST_SAFE |->
         rsp_seq_index == '0 && rsp_seq_process == '0 && rsp_last)
      else $error("malformed single result beat");

   // The final safe beat carries the last sequence position.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dasu_pkg::ST_SAFE |->
         rsp_last == (rsp_seq_index == dasu_pkg::SEQ_BITS'(NUM_PROCESSES - 1)))
      else $error("last flag does not match sequence position");

   // Safe sequence beats follow one another without gaps in position.
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == dasu_pkg::ST_SAFE && !rsp_last |=>
         rsp_valid && rsp_status == dasu_pkg::ST_SAFE &&
         rsp_seq_index == $past(rsp_seq_index) + 3'd1)
      else $error("safe sequence beat missing or out of order");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind deadlock_avoidance_safety_unit dasu_checker #(
   .NUM_PROCESSES (NUM_PROCESSES)
) u_dasu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_seq_index   (rsp.seq_index),
   .rsp_seq_process (rsp.seq_process),
   .rsp_last        (rsp.last)
);
